[sv/iqp_pkg.sv]
`timescale 1ns / 1ps

package iqp_pkg;

  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [9:0] OctetMax  = 10'd255;
  localparam logic [4:0] LenMin    = 5'd7;
  localparam logic [4:0] LenMax    = 5'd15;
  localparam logic [4:0] LenSat    = 5'd16;
  localparam logic [1:0] DigitsMax = 2'd3;
  localparam logic [1:0] PartsLast = 2'd3;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } iqp_result_t;

  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] character;
  } iqp_item_t;

endpackage

[sv/iqp_core.sv]
`timescale 1ns / 1ps

module iqp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iqp_pkg::iqp_item_t item_i,
  output iqp_pkg::iqp_result_t result_o
);
  import iqp_pkg::*;

  logic [9:0]  part_value_q, part_value_d;
  logic [1:0]  part_digits_q, part_digits_d;
  logic [1:0]  part_index_q, part_index_d;
  logic [4:0]  length_count_q, length_count_d;
  logic        error_seen_q, error_seen_d;
  logic [23:0] held_octets_q, held_octets_d;

  logic        is_digit;
  logic        is_dot;
  logic [13:0] acc_wide;
  logic        good;

  assign is_digit = (item_i.character >= ZeroChar) && (item_i.character <= NineChar);
  assign is_dot   = (item_i.character == DotChar);
  assign acc_wide = {1'b0, part_value_q, 3'b000} + {3'b000, part_value_q, 1'b0}
                  + {10'd0, item_i.character[3:0]};

  always_comb begin
    part_value_d   = part_value_q;
    part_digits_d  = part_digits_q;
    part_index_d   = part_index_q;
    error_seen_d   = error_seen_q;
    held_octets_d  = held_octets_q;
    length_count_d = (length_count_q < LenSat) ? length_count_q + 5'd1 : length_count_q;
    if (is_digit) begin
      if (part_digits_q >= DigitsMax) begin
        error_seen_d = 1'b1;
      end else begin
        part_value_d  = acc_wide[9:0];
        part_digits_d = part_digits_q + 2'd1;
      end
    end else if (is_dot) begin
      if ((part_digits_q == 2'd0) || (part_value_q > OctetMax) ||
          (part_index_q >= PartsLast)) begin
        error_seen_d = 1'b1;
      end else begin
        held_octets_d = {held_octets_q[15:0], part_value_q[7:0]};
        part_index_d  = part_index_q + 2'd1;
      end
      part_value_d  = 10'd0;
      part_digits_d = 2'd0;
    end else begin
      error_seen_d = 1'b1;
    end
  end

  assign good = !error_seen_d && (length_count_d >= LenMin) && (length_count_d <= LenMax)
             && (part_index_d == PartsLast) && (part_digits_d != 2'd0)
             && (part_value_d <= OctetMax);

  assign result_o.ok      = good;
  assign result_o.address = good ? {held_octets_d, part_value_d[7:0]} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_value_q   <= '0;
      part_digits_q  <= '0;
      part_index_q   <= '0;
      length_count_q <= '0;
      error_seen_q   <= 1'b0;
      held_octets_q  <= '0;
    end else if (item_i.step) begin
      if (item_i.last) begin
        part_value_q   <= '0;
        part_digits_q  <= '0;
        part_index_q   <= '0;
        length_count_q <= '0;
        error_seen_q   <= 1'b0;
        held_octets_q  <= '0;
      end else begin
        part_value_q   <= part_value_d;
        part_digits_q  <= part_digits_d;
        part_index_q   <= part_index_d;
        length_count_q <= length_count_d;
        error_seen_q   <= error_seen_d;
        held_octets_q  <= held_octets_d;
      end
    end
  end

endmodule

[sv/ipv4_dotted_quad_parser.sv]
`timescale 1ns / 1ps
// A closing item goes from the input register through the core to the result register.
// The parser takes one character per cycle; the input register and result register
// decouple the two channels, so input stalls only when both are full with a closing item.
// Reset: asynchronous, active low; clears the input and result valid flags and all
// parse state (part value, digit count, part index, length count, error flag, octets).

module ipv4_dotted_quad_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] address_o
);
  import iqp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        out_valid_q;
  logic        ok_q;
  logic [31:0] address_q;
  logic        out_free;
  logic        advance;
  iqp_item_t   item;
  iqp_result_t result;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || advance;

  assign item.step      = advance;
  assign item.last      = last_q;
  assign item.character = char_q;

  iqp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= character_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && last_q) begin
      ok_q      <= result.ok;
      address_q <= result.address;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign address_o   = address_q;

  a_zero_addr_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> address_o == 32'd0)
    else $error("address not zero on rejected string");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && last_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked closing item");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && last_q))
    else $error("result appeared without a closing item");

endmodule
